// File: rtl/srt_scheduler_with_starvation_assert.svh
// Assertion macros for the task scheduler block.
// Used by the top level only; relies on clk_i and rst_ni being in scope.
`ifndef SRT_SCHEDULER_WITH_STARVATION_ASSERT_SVH
`define SRT_SCHEDULER_WITH_STARVATION_ASSERT_SVH
`ifndef SYNTHESIS
`define SRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scheduler assertion failed");
`define SRT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define SRT_ASSERT(lbl, prop)
`define SRT_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

// File: rtl/srt_pkg.sv
// Shared types, codes and constants of the task scheduler block.
// No dependencies; used by the channel interfaces and the top level.
package srt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned OCC_W           = 5;
  localparam logic [TIME_W-1:0] LIMIT_RESET = 32'd100;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SELECT = 1'b1
  } op_e;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] remaining_time;
    logic [TIME_W-1:0] last_run_time;
    logic [TIME_W-1:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              chosen_valid;
    logic [ID_W-1:0]   chosen_id;
    logic [TIME_W-1:0] chosen_remaining;
    logic [TIME_W-1:0] chosen_last_run;
    logic              chosen_starved;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] last_run;
  } entry_t;

  // A task is starved when the wrapping difference is non-negative and
  // has reached the limit.
  function automatic logic is_starved(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] last,
                                      input logic [TIME_W-1:0] limit);
    logic [TIME_W-1:0] diff;
    diff = now - last;
    return !diff[TIME_W-1] && (diff >= limit);
  endfunction

endpackage

// File: rtl/srt_if.sv
// Valid/ready channel interfaces of the task scheduler block.
// Depends on srt_pkg for the payload types.
interface srt_in_if;
  logic             valid;
  logic             ready;
  srt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srt_out_if;
  logic               valid;
  logic               ready;
  srt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [srt_pkg::TIME_W-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/srt_scheduler_with_starvation.sv
// Shortest-remaining-time scheduler with starvation aging: top level.
// Depends on srt_pkg, the interfaces in srt_if.sv and the assertion header.
//
// Usage: in_i carries one transaction per item. An insert places a task in a
// table kept sorted by ascending id (a new task goes ahead of equal ids), or
// is refused with a full status. A select removes the first starved task in
// table order or, failing that, the first task with the least remaining
// time. out_o returns one transaction per item with status and occupancy.
// cfg_i writes the 32-bit starvation limit; it is always ready.
// Timing: the table sits in a single-port-write, single-read memory whose
// read data is registered, and one sequencer walks it an entry a cycle. An
// insert shifts entries up, from the top down, until it makes room. A select
// scans entries until a starved task or the end, then the entries above the
// chosen one move down. Full inserts and empty selects skip the table walk
// and go straight to the result. The same comparator serves the id search
// on insert and the remaining-time minimum on select.
// A finished result sits in an output register, so the next transaction is
// accepted while the receiver stalls; a second result waits until the first
// has gone. Reset empties the table (count to zero, no clearing pass) and
// sets the limit to 100.
module srt_scheduler_with_starvation #(
  parameter int unsigned TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srt_in_if.sink      in_i,
  srt_out_if.source   out_o,
  srt_cfg_if.sink     cfg_i
);

  `include "srt_scheduler_with_starvation_assert.svh"

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_SEL  = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  logic [CW-1:0]                  count_q, count_d;
  logic [CW-1:0]                  k_q, k_d;
  logic [srt_pkg::TIME_W-1:0]     limit_q;
  srt_pkg::in_item_t              item_q;
  srt_pkg::entry_t                best_q, best_d;
  logic [IW-1:0]                  best_idx_q, best_idx_d;
  logic                           starved_q, starved_d;
  srt_pkg::status_e               status_q, status_d;
  logic                           out_valid_q;
  srt_pkg::out_item_t             out_q, res;

  // Table memory.
  srt_pkg::entry_t                table_q [TABLE_DEPTH];
  srt_pkg::entry_t                rd_q;
  logic [IW-1:0]                  rd_addr, wr_addr;
  logic                           wr_en;
  srt_pkg::entry_t                wr_data;

  logic                           in_acc, out_load;
  srt_pkg::entry_t                new_ent, cand_ent;
  logic [IW-1:0]                  cand_idx;
  logic [srt_pkg::TIME_W-1:0]     cmp_a, cmp_b;
  logic                           cmp_lt, rd_starved, upd;
  logic [CW-1:0]                  k_m1, k_m2, k_p1, k_p2, cnt_m1;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign new_ent.id        = item_q.task_id;
  assign new_ent.remaining = item_q.remaining_time;
  assign new_ent.last_run  = item_q.last_run_time;

  assign k_m1   = k_q - CW'(1);
  assign k_m2   = k_q - CW'(2);
  assign k_p1   = k_q + CW'(1);
  assign k_p2   = k_q + CW'(2);
  assign cnt_m1 = count_q - CW'(1);

  // The shared comparator: ids while inserting, remaining times while
  // selecting.
  always_comb begin
    if (state_q == S_INS) begin
      cmp_a = {{(srt_pkg::TIME_W - srt_pkg::ID_W){1'b0}}, rd_q.id};
      cmp_b = {{(srt_pkg::TIME_W - srt_pkg::ID_W){1'b0}}, item_q.task_id};
    end else begin
      cmp_a = rd_q.remaining;
      cmp_b = best_q.remaining;
    end
  end
  assign cmp_lt     = cmp_a < cmp_b;
  assign rd_starved = srt_pkg::is_starved(item_q.current_time, rd_q.last_run, limit_q);

  // Candidate for the least remaining time, including the entry now read.
  assign upd      = (k_q == '0) || cmp_lt;
  assign cand_ent = upd ? rd_q : best_q;
  assign cand_idx = upd ? k_q[IW-1:0] : best_idx_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    k_d        = k_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    starved_d  = starved_q;
    status_d   = status_q;
    wr_en      = 1'b0;
    wr_addr    = k_q[IW-1:0];
    wr_data    = rd_q;
    rd_addr    = '0;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          starved_d = 1'b0;
          if (in_i.data.op == srt_pkg::OP_INSERT) begin
            if (count_q == DepthC) begin
              status_d = srt_pkg::ST_FULL;
              state_d  = S_DONE;
            end else begin
              // Walk down from the top, reading the entry below the slot.
              k_d     = count_q;
              rd_addr = cnt_m1[IW-1:0];
              state_d = S_INS;
            end
          end else begin
            if (count_q == '0) begin
              status_d = srt_pkg::ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              k_d     = '0;
              rd_addr = '0;
              state_d = S_SEL;
            end
          end
        end
      end

      S_INS: begin
        // rd_q holds entry k-1 whenever k is not zero.
        if (k_q == '0 || cmp_lt) begin
          wr_en    = 1'b1;
          wr_data  = new_ent;
          count_d  = count_q + CW'(1);
          status_d = srt_pkg::ST_OK;
          state_d  = S_DONE;
        end else begin
          wr_en   = 1'b1;
          k_d     = k_m1;
          rd_addr = k_m2[IW-1:0];
        end
      end

      S_SEL: begin
        // rd_q holds entry k.
        if (rd_starved) begin
          best_d     = rd_q;
          best_idx_d = k_q[IW-1:0];
          starved_d  = 1'b1;
          rd_addr    = k_p1[IW-1:0];
          state_d    = S_CMP;
        end else begin
          best_d     = cand_ent;
          best_idx_d = cand_idx;
          if (k_p1 == count_q) begin
            k_d     = CW'(cand_idx);
            rd_addr = cand_idx + IW'(1);
            state_d = S_CMP;
          end else begin
            k_d     = k_p1;
            rd_addr = k_p1[IW-1:0];
          end
        end
      end

      S_CMP: begin
        // Close the gap: rd_q holds entry k+1 while k+1 is below the count.
        if (k_p1 >= count_q) begin
          count_d  = cnt_m1;
          status_d = srt_pkg::ST_OK;
          state_d  = S_DONE;
        end else begin
          wr_en   = 1'b1;
          k_d     = k_p1;
          rd_addr = k_p2[IW-1:0];
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result assembly; only a completed select reports a task.
  always_comb begin
    res                  = '0;
    res.status           = status_q;
    res.occupancy        = srt_pkg::OCC_W'(count_q);
    if (status_q == srt_pkg::ST_OK && item_q.op == srt_pkg::OP_SELECT) begin
      res.chosen_valid     = 1'b1;
      res.chosen_id        = best_q.id;
      res.chosen_remaining = best_q.remaining;
      res.chosen_last_run  = best_q.last_run;
      res.chosen_starved   = starved_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_addr] <= wr_data;
    end
    rd_q <= table_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      limit_q     <= srt_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
      if (cfg_i.valid && cfg_i.ready) begin
        limit_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i.data;
    end
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    starved_q  <= starved_d;
    status_q   <= status_d;
    if (out_load) begin
      out_q <= res;
    end
  end

  // The table never holds more tasks than it has entries.
  `SRT_ASSERT(a_count_bound, count_q <= DepthC)
  // An insert into a full table is refused without touching the table.
  `SRT_ASSERT_MSG(a_full_refused,
    (in_acc && in_i.data.op == srt_pkg::OP_INSERT && count_q == DepthC)
      |=> (state_q == S_DONE && status_q == srt_pkg::ST_FULL && $stable(count_q)),
    "full insert not refused")
  // The occupancy moves only when an insert or a removal completes.
  `SRT_ASSERT_MSG(a_count_change,
    (count_q != $past(count_q)) |-> ($past(state_q) == S_INS || $past(state_q) == S_CMP),
    "occupancy changed outside completion")
  // A scan only runs over a non-empty table.
  `SRT_ASSERT(a_scan_nonempty, (state_q == S_SEL || state_q == S_CMP) |-> (count_q != '0))

endmodule
